[design/ste_pkg.sv]
package ste_pkg;

  // Operation codes carried by an input item.
  localparam logic [2:0] OP_WRITE  = 3'd0;
  localparam logic [2:0] OP_EXACT  = 3'd1;
  localparam logic [2:0] OP_FIRST  = 3'd2;
  localparam logic [2:0] OP_LAST   = 3'd3;
  localparam logic [2:0] OP_COUNT  = 3'd4;
  localparam logic [2:0] OP_LINEAR = 3'd5;

  // Fixed field widths of the channels and the length register.
  localparam int unsigned POS_W = 10;
  localparam int unsigned LEN_W = 11;
  localparam int unsigned KEY_W = 32;

  typedef struct packed {
    logic [2:0]              operation;
    logic [POS_W-1:0]        entry_index;
    logic signed [KEY_W-1:0] key_value;
  } ste_in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic [LEN_W-1:0] occurrences;
  } ste_out_t;

endpackage

[design/sorted_table_search_engine.sv]
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_ready  ste_pkg::ste_in_t (operation, entry_index, key_value)
// out_      output     out_valid/out_ready ste_pkg::ste_out_t (found, position, occurrences)
// cfg_      input      cfg_we             cfg_wdata = table_length
//
// One item is worked on at a time. A write item gives no result. Exact, first and last
// are binary searches, count runs a first-occurrence pass and, on a hit, a last-occurrence
// pass, and linear mode scans the entries from index 0 until a hit or the end of the table.
// Each probe is one read of the table memory followed by one compare.
// Reset is synchronous and active low; the table itself is not cleared. The output register
// holds a finished item while the next item is accepted; a stalled output holds the sequencer.
module sorted_table_search_engine #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ste_pkg::ste_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ste_pkg::ste_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [ste_pkg::LEN_W-1:0]     cfg_wdata
);
  import ste_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = $clog2(DEPTH + 1) + 1;

  logic [LEN_W-1:0]              table_length_r;
  logic                          out_valid_r, out_valid_nxt;
  ste_out_t                      out_r;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic signed [VALUE_WIDTH-1:0] wr_data;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic signed [VALUE_WIDTH-1:0] rd_data;
  logic                          done;
  ste_out_t                      result;
  logic                          take;

  // Length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r <= '0;
    end else if (cfg_we) begin
      table_length_r <= cfg_wdata;
    end
  end

  ste_mem #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH),
    .AW         (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  ste_ctrl #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH),
    .AW         (AW),
    .PW         (PW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .table_length(table_length_r),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .done        (done),
    .result      (result),
    .take        (take)
  );

  // Output register: load a finished item when the slot is free or being emptied.
  assign take = done && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[design/ste_mem.sv]
module ste_mem #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32,
  parameter int AW          = 10
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic signed [VALUE_WIDTH-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic signed [VALUE_WIDTH-1:0] rd_data
);

  logic signed [VALUE_WIDTH-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/ste_ctrl.sv]
module ste_ctrl #(
  parameter int DEPTH       = 1024,
  parameter int VALUE_WIDTH = 32,
  parameter int AW          = 10,
  parameter int PW          = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ste_pkg::ste_in_t              in_data,
  input  logic [ste_pkg::LEN_W-1:0]     table_length,
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output logic signed [VALUE_WIDTH-1:0] wr_data,
  output logic                          rd_en,
  output logic [AW-1:0]                 rd_addr,
  input  logic signed [VALUE_WIDTH-1:0] rd_data,
  output logic                          done,
  output ste_pkg::ste_out_t             result,
  input  logic                          take
);
  import ste_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic signed [PW-1:0] ONE = PW'(1);
  localparam logic signed [PW-1:0] NEG_ONE = -ONE;

  logic [1:0]                    state_r, state_nxt;
  logic [2:0]                    mode_r, mode_nxt;
  logic                          pass_r, pass_nxt;
  logic                          hit_r, hit_nxt;
  logic signed [VALUE_WIDTH-1:0] target_r, target_nxt;
  logic signed [PW-1:0]          low_r, low_nxt;
  logic signed [PW-1:0]          high_r, high_nxt;
  logic signed [PW-1:0]          mid_r, mid_nxt;
  logic signed [PW-1:0]          ans_r, ans_nxt;
  logic signed [PW-1:0]          first_r, first_nxt;
  ste_out_t                      res_r, res_nxt;

  logic                          accept;
  logic [31:0]                   idx_w;
  logic [31:0]                   len_w;
  logic [31:0]                   len_sat;
  logic signed [PW-1:0]          len_pw;
  logic signed [PW-1:0]          high_init;
  logic signed [PW-1:0]          mid_calc;
  logic signed [PW-1:0]          occ_s;
  logic [31:0]                   mid_w;
  logic [31:0]                   ans_w;
  logic [31:0]                   occ_w;
  logic                          go_left;
  logic                          eq;
  logic                          lt;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  // Writes go straight to the table; indexes beyond the depth are dropped.
  assign idx_w   = 32'(in_data.entry_index);
  assign wr_en   = accept && (in_data.operation == OP_WRITE) && (idx_w < 32'(DEPTH));
  assign wr_addr = idx_w[AW-1:0];
  assign wr_data = VALUE_WIDTH'(in_data.key_value);

  // Entries in use, saturated at the depth.
  assign len_w     = 32'(table_length);
  assign len_sat   = (len_w > 32'(DEPTH)) ? 32'(DEPTH) : len_w;
  assign len_pw    = PW'(len_sat);
  assign high_init = len_pw - ONE;

  // Probe point: midpoint for the binary modes, the scan pointer for linear mode.
  assign mid_calc = (mode_r == OP_LINEAR) ? low_r : (low_r + ((high_r - low_r) >>> 1));
  assign rd_en    = (state_r == S_READ);
  assign rd_addr  = mid_calc[AW-1:0];

  assign eq      = (rd_data == target_r);
  assign lt      = (rd_data < target_r);
  assign go_left = (mode_r == OP_FIRST) || ((mode_r == OP_COUNT) && !pass_r);

  assign occ_s = ans_r - first_r + ONE;
  assign mid_w = 32'(mid_r);
  assign ans_w = 32'(ans_r);
  assign occ_w = 32'(occ_s);

  assign done   = (state_r == S_DONE);
  assign result = res_r;

  // Sequencer: one probe is a read state followed by a compare state.
  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    pass_nxt   = pass_r;
    hit_nxt    = hit_r;
    target_nxt = target_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    mid_nxt    = mid_r;
    ans_nxt    = ans_r;
    first_nxt  = first_r;
    res_nxt    = res_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.operation)
            OP_EXACT, OP_FIRST, OP_LAST, OP_COUNT, OP_LINEAR: begin
              mode_nxt   = in_data.operation;
              target_nxt = VALUE_WIDTH'(in_data.key_value);
              low_nxt    = '0;
              high_nxt   = high_init;
              ans_nxt    = NEG_ONE;
              hit_nxt    = 1'b0;
              pass_nxt   = 1'b0;
              state_nxt  = S_READ;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        if (low_r > high_r) begin
          // Bounds crossed: the search is over.
          if (mode_r == OP_COUNT && !pass_r) begin
            if (hit_r) begin
              first_nxt = ans_r;
              ans_nxt   = NEG_ONE;
              hit_nxt   = 1'b0;
              pass_nxt  = 1'b1;
              low_nxt   = '0;
              high_nxt  = high_init;
              state_nxt = S_READ;
            end else begin
              res_nxt   = '0;
              state_nxt = S_DONE;
            end
          end else if (mode_r == OP_COUNT) begin
            res_nxt.found       = 1'b1;
            res_nxt.position    = '0;
            res_nxt.occurrences = occ_w[LEN_W-1:0];
            state_nxt           = S_DONE;
          end else begin
            res_nxt.found       = hit_r;
            res_nxt.position    = hit_r ? ans_w[POS_W-1:0] : '0;
            res_nxt.occurrences = '0;
            state_nxt           = S_DONE;
          end
        end else begin
          mid_nxt   = mid_calc;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_READ;
        if (eq && (mode_r == OP_EXACT || mode_r == OP_LINEAR)) begin
          res_nxt.found       = 1'b1;
          res_nxt.position    = mid_w[POS_W-1:0];
          res_nxt.occurrences = '0;
          state_nxt           = S_DONE;
        end else if (eq) begin
          ans_nxt = mid_r;
          hit_nxt = 1'b1;
          if (go_left) begin
            high_nxt = mid_r - ONE;
          end else begin
            low_nxt = mid_r + ONE;
          end
        end else if (lt || mode_r == OP_LINEAR) begin
          low_nxt = mid_r + ONE;
        end else begin
          high_nxt = mid_r - ONE;
        end
      end
      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state is reset; search registers are payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    pass_r   <= pass_nxt;
    hit_r    <= hit_nxt;
    target_r <= target_nxt;
    low_r    <= low_nxt;
    high_r   <= high_nxt;
    mid_r    <= mid_nxt;
    ans_r    <= ans_nxt;
    first_r  <= first_nxt;
    res_r    <= res_nxt;
  end

endmodule
